FILE: design/facull_pkg.sv
`default_nettype none
package facull_pkg;

  // Register layout: normal x, y, z in Q1.10, distance in Q17.10
  localparam int PLANE_W   = 64;
  localparam int PLANE_CNT = 6;
  localparam int NORM_W    = 12;
  localparam int DIST_W    = 28;
  localparam int DIST_LSB  = 3 * NORM_W;
  localparam int CFG_IDX_W = 3;

  // Chunk grid coordinates and box edge lengths in world units
  localparam int CHUNK_W = 12;
  localparam int SIZE_X  = 32;
  localparam int SIZE_Y  = 32;
  localparam int SIZE_Z  = 32;
  localparam int SIZE_XY  = (SIZE_X > SIZE_Y) ? SIZE_X : SIZE_Y;
  localparam int SIZE_MAX = (SIZE_XY > SIZE_Z) ? SIZE_XY : SIZE_Z;

  // Box corners reach (2^(CHUNK_W-1)) * SIZE in magnitude, max side included
  localparam int COORD_W = $clog2((2 ** (CHUNK_W - 1)) * SIZE_MAX + 1) + 1;
  localparam int PROD_W  = COORD_W + NORM_W;
  localparam int ACC_HI  = (PROD_W + 2 > DIST_W) ? PROD_W + 2 : DIST_W;
  localparam int ACC_W   = ACC_HI + 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    PLANE_LEFT,
    PLANE_RIGHT,
    PLANE_BOTTOM,
    PLANE_TOP,
    PLANE_NEAR,
    PLANE_FAR
  } plane_idx_t;

  localparam plane_idx_t PLANE_IDX [PLANE_CNT] = '{
    PLANE_LEFT, PLANE_RIGHT, PLANE_BOTTOM, PLANE_TOP, PLANE_NEAR, PLANE_FAR
  };

  typedef logic signed [COORD_W-1:0] coord_t;

  // Word handed along the chain of plane cells
  typedef struct packed {
    coord_t [2:0] lo;
    coord_t [2:0] hi;
    logic         vis;
  } item_t;

endpackage
`default_nettype wire

FILE: design/facull_corner.sv
`default_nettype none
module facull_corner import facull_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_vld,
  output logic                    up_rdy,
  input  wire logic [CHUNK_W-1:0] chunk_x,
  input  wire logic [CHUNK_W-1:0] chunk_y,
  input  wire logic [CHUNK_W-1:0] chunk_z,
  output logic                    dn_vld,
  input  wire logic               dn_rdy,
  output item_t                   dn_item
);

  localparam coord_t SIZE_C [3] = '{
    COORD_W'(SIZE_X), COORD_W'(SIZE_Y), COORD_W'(SIZE_Z)
  };

  logic   vld_r;
  logic   vld_nxt;
  item_t  item_r;
  item_t  item_nxt;
  coord_t chunk_ext [3];

  // Widen the grid position to world-coordinate width
  always_comb begin
    chunk_ext[0] = COORD_W'($signed(chunk_x));
    chunk_ext[1] = COORD_W'($signed(chunk_y));
    chunk_ext[2] = COORD_W'($signed(chunk_z));
  end

  assign up_rdy = !vld_r || dn_rdy;

  // Form the min and max corner of the box on each axis
  always_comb begin
    item_nxt     = item_r;
    item_nxt.vis = 1'b1;
    for (int a = 0; a < 3; a++) begin
      item_nxt.lo[a] = chunk_ext[a] * SIZE_C[a];
      item_nxt.hi[a] = chunk_ext[a] * SIZE_C[a] + SIZE_C[a];
    end
  end

  assign vld_nxt = up_rdy ? up_vld : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_vld && up_rdy) begin
      item_r <= item_nxt;
    end
  end

  assign dn_vld  = vld_r;
  assign dn_item = item_r;

  // A freshly formed word always starts as visible
  a_fresh_vis: assert property (@(posedge clk) disable iff (!rst_n)
    up_vld && up_rdy |=> vld_r && item_r.vis)
    else $error("corner stage loaded a word already marked culled");

endmodule
`default_nettype wire

FILE: design/facull_cell.sv
`default_nettype none
module facull_cell import facull_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr,
  input  wire logic [PLANE_W-1:0] cfg_data,
  input  wire logic               up_vld,
  output logic                    up_rdy,
  input  wire item_t              up_item,
  output logic                    dn_vld,
  input  wire logic               dn_rdy,
  output item_t                   dn_item
);

  logic [PLANE_W-1:0]      plane_r;
  logic                    vld_a_r;
  logic                    vld_a_nxt;
  item_t                   item_a_r;
  logic signed [PROD_W-1:0] prod_r   [3];
  logic signed [PROD_W-1:0] prod_nxt [3];
  logic                    vld_b_r;
  logic                    vld_b_nxt;
  item_t                   item_b_r;
  item_t                   item_b_nxt;
  logic                    rdy_a;
  logic                    rdy_b;
  logic signed [NORM_W-1:0] norm     [3];
  logic signed [PROD_W-1:0] norm_ext [3];
  logic signed [PROD_W-1:0] pick_ext [3];
  logic signed [DIST_W-1:0] plane_dist;
  logic signed [ACC_W-1:0]  acc;

  // Hold the plane written by software
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (cfg_wr) begin
      plane_r <= cfg_data;
    end
  end

  // Stall chain: a stage takes a word when empty or when it empties
  assign rdy_b  = !vld_b_r || dn_rdy;
  assign rdy_a  = !vld_a_r || rdy_b;
  assign up_rdy = rdy_a;

  // Pick the corner farthest along the normal, one product per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      norm[a]     = $signed(plane_r[a*NORM_W +: NORM_W]);
      norm_ext[a] = PROD_W'(norm[a]);
      pick_ext[a] = norm[a][NORM_W-1] ? PROD_W'($signed(up_item.lo[a]))
                                      : PROD_W'($signed(up_item.hi[a]));
      prod_nxt[a] = norm_ext[a] * pick_ext[a];
    end
  end

  assign vld_a_nxt = rdy_a ? up_vld : vld_a_r;

  // Sum the products with the distance and drop visibility on a negative result
  assign plane_dist = $signed(plane_r[DIST_LSB +: DIST_W]);
  assign acc  = ACC_W'(plane_dist) + ACC_W'(prod_r[0]) + ACC_W'(prod_r[1])
              + ACC_W'(prod_r[2]);

  always_comb begin
    item_b_nxt     = item_a_r;
    item_b_nxt.vis = item_a_r.vis && !acc[ACC_W-1];
  end

  assign vld_b_nxt = rdy_b ? vld_a_r : vld_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= vld_a_nxt;
      vld_b_r <= vld_b_nxt;
    end
  end

  // Advance the payload only when the stage takes a word
  always_ff @(posedge clk) begin
    if (up_vld && rdy_a) begin
      item_a_r <= up_item;
      prod_r   <= prod_nxt;
    end
    if (vld_a_r && rdy_b) begin
      item_b_r <= item_b_nxt;
    end
  end

  assign dn_vld  = vld_b_r;
  assign dn_item = item_b_r;

  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_b_r && !dn_rdy |=> vld_b_r && $stable(item_b_r))
    else $error("blocked sum stage lost or changed its word");

  a_a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_a_r && !rdy_b |=> vld_a_r && $stable(item_a_r))
    else $error("blocked product stage lost or changed its word");

  a_no_revive: assert property (@(posedge clk) disable iff (!rst_n)
    vld_a_r && rdy_b && !item_a_r.vis |=> !item_b_r.vis)
    else $error("culled word became visible again in a plane cell");

endmodule
`default_nettype wire

FILE: design/frustum_aabb_cull_test_unit.sv
`default_nettype none
// Frustum cull test for chunk boxes. Each accepted word is a chunk grid
// position; the block returns one word per input with out_visible = 0 when
// some plane has the whole box on its negative side, else 1. Words enter at
// one per cycle when nothing stalls and leave in order: one stage forms the
// box corners, then each of the six plane cells spends two stages (three
// corner products, then the sum with the distance and the sign test).
// Write planes over the cfg port only while no word is in flight; the block
// does not enforce it. After reset all planes are zero and cull nothing.
module frustum_aabb_cull_test_unit import facull_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PLANE_W-1:0]   cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CHUNK_W-1:0]   in_chunk_x,
  input  wire logic [CHUNK_W-1:0]   in_chunk_y,
  input  wire logic [CHUNK_W-1:0]   in_chunk_z,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_visible
);

  logic  chain_vld  [PLANE_CNT+1];
  logic  chain_rdy  [PLANE_CNT+1];
  item_t chain_item [PLANE_CNT+1];
  logic  in_rdy;

  facull_corner u_corner (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (in_valid),
    .up_rdy  (in_rdy),
    .chunk_x (in_chunk_x),
    .chunk_y (in_chunk_y),
    .chunk_z (in_chunk_z),
    .dn_vld  (chain_vld[0]),
    .dn_rdy  (chain_rdy[0]),
    .dn_item (chain_item[0])
  );

  // One cell per plane, each decoding its own register index
  for (genvar i = 0; i < PLANE_CNT; i++) begin : g_cell
    logic cell_wr;

    assign cell_wr = cfg_we && (cfg_index == PLANE_IDX[i]);

    facull_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg_wr   (cell_wr),
      .cfg_data (cfg_data),
      .up_vld   (chain_vld[i]),
      .up_rdy   (chain_rdy[i]),
      .up_item  (chain_item[i]),
      .dn_vld   (chain_vld[i+1]),
      .dn_rdy   (chain_rdy[i+1]),
      .dn_item  (chain_item[i+1])
    );
  end

  assign chain_rdy[PLANE_CNT] = !out_stall;
  assign in_stall    = !in_rdy;
  assign out_valid   = chain_vld[PLANE_CNT];
  assign out_visible = chain_item[PLANE_CNT].vis;

  // Input only backs up when the result word itself is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output was free");

endmodule
`default_nettype wire

FILE: tb/frustum_aabb_cull_test_unit_tb.sv
`timescale 1ns / 1ps
module frustum_aabb_cull_test_unit_tb;
  import facull_pkg::*;

  // Nominal input-to-output delay with no stall, and the stuck-run limit
  localparam int PIPE_LAT    = 13;
  localparam int STUCK_LIMIT = 4000;
  localparam int N_PHASES    = 8;
  localparam int PHASE_WORDS = 242;
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 80;
  localparam int BURST_LO    = 1100;
  localparam int BURST_HI    = 1350;

  // Register indexes past the last plane; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] IDX_NONE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_NONE_HI = 3'd7;

  // Chunk coordinate corners
  localparam logic [CHUNK_W-1:0] C_MIN  = 12'h800;
  localparam logic [CHUNK_W-1:0] C_MAX  = 12'h7FF;
  localparam logic [CHUNK_W-1:0] C_NEG1 = 12'hFFF;
  localparam logic [CHUNK_W-1:0] C_NEG2 = 12'hFFE;

  // Plane words: {distance, nz, ny, nx}
  localparam logic [PLANE_W-1:0] PL_ZERO     = 64'd0;
  localparam logic [PLANE_W-1:0] PL_XPOS     = {28'h0000000, 12'h000, 12'h000, 12'h400};
  localparam logic [PLANE_W-1:0] PL_CULL_ALL = {28'hFFFFFFF, 36'd0};
  localparam logic [PLANE_W-1:0] PL_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [PLANE_W-1:0] PL_MAX_DIST = {28'h7FFFFFF, 12'h7FF, 12'h800, 12'h7FF};
  localparam logic [PLANE_W-1:0] PL_MIN_DIST = {28'h8000000, 12'h800, 12'h7FF, 12'h800};

  typedef enum logic [0:0] {ROW_ITEM, ROW_PLANE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [PLANE_W-1:0]   data;
    logic [CHUNK_W-1:0]   cx;
    logic [CHUNK_W-1:0]   cy;
    logic [CHUNK_W-1:0]   cz;
    bit                   typed;
    bit                   vis;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  // Directed rows: empty frustum, single x plane, dropped writes, extremes
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     12'd0,  12'd0,  12'd0,  1'b1, 1'b1},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     C_MIN,  C_MIN,  C_MIN,  1'b1, 1'b1},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     C_MAX,  C_MAX,  C_MAX,  1'b1, 1'b1},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     C_MAX,  C_MIN,  C_NEG1, 1'b1, 1'b1},
    '{ROW_PLANE, PLANE_LEFT,   PL_XPOS,     12'd0,  12'd0,  12'd0,  1'b0, 1'b0},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     C_NEG1, 12'd5,  12'hFF9, 1'b1, 1'b1},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     C_NEG2, 12'd0,  12'd0,  1'b1, 1'b0},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     C_MIN,  C_MAX,  C_MAX,  1'b1, 1'b0},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     C_MAX,  C_MIN,  C_MIN,  1'b1, 1'b1},
    '{ROW_PLANE, IDX_NONE_LO,  PL_CULL_ALL, 12'd0,  12'd0,  12'd0,  1'b0, 1'b0},
    '{ROW_PLANE, IDX_NONE_HI,  PL_CULL_ALL, 12'd0,  12'd0,  12'd0,  1'b0, 1'b0},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     12'd0,  12'd0,  12'd0,  1'b1, 1'b1},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     C_NEG2, 12'd0,  12'd0,  1'b1, 1'b0},
    '{ROW_PLANE, PLANE_RIGHT,  PL_MAX_DIST, 12'd0,  12'd0,  12'd0,  1'b0, 1'b0},
    '{ROW_PLANE, PLANE_BOTTOM, PL_MIN_DIST, 12'd0,  12'd0,  12'd0,  1'b0, 1'b0},
    '{ROW_PLANE, PLANE_TOP,    PL_ALL_ONES, 12'd0,  12'd0,  12'd0,  1'b0, 1'b0},
    '{ROW_PLANE, PLANE_NEAR,   PL_MIN_DIST, 12'd0,  12'd0,  12'd0,  1'b0, 1'b0},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     12'd0,  12'd0,  12'd0,  1'b0, 1'b0},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     C_MAX,  C_MAX,  C_MAX,  1'b0, 1'b0},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     C_MIN,  C_MIN,  C_MIN,  1'b0, 1'b0},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     12'd1,  C_NEG1, 12'd1,  1'b0, 1'b0},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     C_MIN,  C_MAX,  12'd0,  1'b0, 1'b0},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     12'd100, 12'hF9C, 12'd37, 1'b0, 1'b0},
    '{ROW_PLANE, PLANE_FAR,    PL_CULL_ALL, 12'd0,  12'd0,  12'd0,  1'b0, 1'b0},
    '{ROW_ITEM,  PLANE_LEFT,   PL_ZERO,     12'd5,  12'd5,  12'd5,  1'b1, 1'b0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PLANE_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [CHUNK_W-1:0] in_chunk_x;
  logic [CHUNK_W-1:0] in_chunk_y;
  logic [CHUNK_W-1:0] in_chunk_z;
  logic out_valid;
  logic out_stall;
  logic out_visible;

  // Plane copy held by the testbench, and the visibility still owed
  logic [PLANE_W-1:0] cull_planes [PLANE_CNT];
  bit pending_visible [$];

  // Expectation for the word on offer: typed in, or left to the predictor
  bit offer_typed;
  bit offer_vis;

  int n_in_acc;
  int n_out;
  int n_culled;
  int n_err;
  int n_settings;
  int stuck;
  bit want;
  bit moved;
  bit hold_done;

  int ph;
  int k;
  int p;
  int mode;
  logic [PLANE_W-1:0] pdata;
  logic [PLANE_W-1:0] pl_extremes [4];
  logic [CHUNK_W-1:0] rx;
  logic [CHUNK_W-1:0] ry;
  logic [CHUNK_W-1:0] rz;

  frustum_aabb_cull_test_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_chunk_x  (in_chunk_x),
    .in_chunk_y  (in_chunk_y),
    .in_chunk_z  (in_chunk_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_visible (out_visible)
  );

  // Positive-vertex test of the chunk box against the six held planes
  function automatic bit box_in_frustum(logic signed [CHUNK_W-1:0] cx,
                                        logic signed [CHUNK_W-1:0] cy,
                                        logic signed [CHUNK_W-1:0] cz);
    longint box_min [3];
    longint box_max [3];
    longint acc;
    longint n;
    bit keep;
    keep = 1'b1;
    box_min[0] = longint'(cx) * SIZE_X;
    box_min[1] = longint'(cy) * SIZE_Y;
    box_min[2] = longint'(cz) * SIZE_Z;
    box_max[0] = box_min[0] + SIZE_X;
    box_max[1] = box_min[1] + SIZE_Y;
    box_max[2] = box_min[2] + SIZE_Z;
    for (int i = 0; i < PLANE_CNT; i++) begin
      acc = longint'($signed(cull_planes[i][DIST_LSB +: DIST_W]));
      for (int a = 0; a < 3; a++) begin
        n = longint'($signed(cull_planes[i][NORM_W*a +: NORM_W]));
        acc += n * ((n >= 0) ? box_max[a] : box_min[a]);
      end
      if (acc < 0) keep = 1'b0;
    end
    return keep;
  endfunction

  function automatic bit no_idle_window();
    return n_in_acc >= BURST_LO && n_in_acc < BURST_HI;
  endfunction

  task automatic report_mismatch(input string what);
    if (n_err < 20) $display("MISMATCH @%0t: %s", $realtime, what);
    n_err++;
  endtask

  // Offer one chunk word after a random gap and hold it until taken
  task automatic offer_chunk(input logic [CHUNK_W-1:0] cx, input logic [CHUNK_W-1:0] cy,
                             input logic [CHUNK_W-1:0] cz, input bit typed, input bit vis);
    int seen;
    while (!no_idle_window() && $urandom_range(99) < 38) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_chunk_x  = cx;
    in_chunk_y  = cy;
    in_chunk_z  = cz;
    offer_typed = typed;
    offer_vis   = vis;
    in_valid    = 1'b1;
    seen = n_in_acc;
    do @(negedge clk); while (n_in_acc == seen);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic settle();
    in_valid = 1'b0;
    while (pending_visible.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_plane(input logic [CFG_IDX_W-1:0] idx, input logic [PLANE_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    if (idx < PLANE_CNT) cull_planes[idx] = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check results against the oldest owed word, then log accepted inputs
  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        n_out++;
        if (pending_visible.size() == 0) begin
          report_mismatch($sformatf("result word %0d arrived with nothing owed", n_out));
        end else begin
          want = pending_visible.pop_front();
          if (out_visible !== want)
            report_mismatch($sformatf("result word %0d: visible %b, want %b",
                                      n_out, out_visible, want));
          if (!want) n_culled++;
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        n_in_acc++;
        pending_visible.push_back(offer_typed ? offer_vis :
                                  box_in_frustum(in_chunk_x, in_chunk_y, in_chunk_z));
      end
      if (cfg_we) moved = 1'b1;
      stuck = moved ? 0 : stuck + 1;
    end
  end

  // Receiver: random stall, one long hold-off, and a stretch with none
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && n_in_acc >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = !rst_n ? 1'b0 : (!no_idle_window() && $urandom_range(99) < 38);
    end
  end

  initial begin
    wait (stuck >= STUCK_LIMIT);
    $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
    $display("frustum_aabb_cull_test_unit_tb: errors");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = PLANE_LEFT;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_chunk_x  = '0;
    in_chunk_y  = '0;
    in_chunk_z  = '0;
    offer_typed = 1'b0;
    offer_vis   = 1'b0;
    n_in_acc    = 0;
    n_out       = 0;
    n_culled    = 0;
    n_err       = 0;
    n_settings  = 1;
    stuck       = 0;
    for (int i = 0; i < PLANE_CNT; i++) cull_planes[i] = PL_ZERO;
    pl_extremes[0] = PL_ALL_ONES;
    pl_extremes[1] = PL_MAX_DIST;
    pl_extremes[2] = PL_MIN_DIST;
    pl_extremes[3] = PL_CULL_ALL;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table; plane writes only once the block is empty
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_PLANE) begin
        settle();
        write_plane(dir_rows[r].idx, dir_rows[r].data);
        n_settings++;
      end else begin
        offer_chunk(dir_rows[r].cx, dir_rows[r].cy, dir_rows[r].cz,
                    dir_rows[r].typed, dir_rows[r].vis);
      end
    end

    // Random phases: fresh planes while idle, then a stream of chunk words
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      for (p = 0; p < PLANE_CNT; p++) begin
        mode = (ph == N_PHASES - 1) ? 3 : $urandom_range(0, 3);
        case (mode)
          0: pdata = {$urandom, $urandom};
          1: pdata = PL_ZERO;
          2: pdata = {28'($urandom_range(0, 67108863)), 36'({$urandom, $urandom})};
          default: pdata = pl_extremes[$urandom_range(0, 2)];
        endcase
        write_plane(PLANE_IDX[p], pdata);
      end
      if ($urandom_range(1)) write_plane($urandom_range(1) ? IDX_NONE_LO : IDX_NONE_HI,
                                         {$urandom, $urandom});
      n_settings++;
      offer_typed = 1'b0;
      for (k = 0; k < PHASE_WORDS; k++) begin
        if ($urandom_range(99) < 35) begin
          rx = 12'($urandom);
          ry = 12'($urandom);
          rz = 12'($urandom);
        end else begin
          rx = 12'($urandom_range(0, 127) - 64);
          ry = 12'($urandom_range(0, 127) - 64);
          rz = 12'($urandom_range(0, 127) - 64);
        end
        offer_chunk(rx, ry, rz, 1'b0, 1'b0);
      end
    end

    // Drain, let the pipe run dry, then report
    in_valid = 1'b0;
    while (pending_visible.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 8) @(negedge clk);
    $display("run covered %0d chunk words and %0d results (%0d culled) over %0d plane sets",
             n_in_acc, n_out, n_culled, n_settings);
    $display("  incl. dropped writes past the last plane and a long output hold-off");
    if (n_err == 0) begin
      $display("frustum_aabb_cull_test_unit_tb: clean");
    end else begin
      $display("frustum_aabb_cull_test_unit_tb: errors");
    end
    $finish;
  end

endmodule
